>>> hdl/vns_pkg.sv
// ----------------------------------------------------------------------------
// vns_pkg
// Shared types and constants of the vector norm sorter: the word formats of
// both channels, the stored entry and the norm unit's step counts.
// ----------------------------------------------------------------------------
package vns_pkg;

  localparam int MAX_VECTORS_DEF = 32;
  localparam int COMP_W          = 16;
  localparam int NORM_W          = 16;

  // sum of four squares needs 33 bits, radicand is padded to an even width
  localparam int SUM_W      = 2 * COMP_W + 1;
  localparam int RAD_W      = 2 * COMP_W + 2;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SQ_STEPS   = 5;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_W     = 5;

  typedef struct packed {
    logic signed [COMP_W-1:0] comp_u;
    logic signed [COMP_W-1:0] comp_x;
    logic signed [COMP_W-1:0] comp_y;
    logic signed [COMP_W-1:0] comp_z;
    logic                     last_vector;
  } vec_word_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] out_u;
    logic signed [COMP_W-1:0] out_x;
    logic signed [COMP_W-1:0] out_y;
    logic signed [COMP_W-1:0] out_z;
    logic        [NORM_W-1:0] out_norm;
    logic                     out_last;
    logic                     overflow;
  } res_word_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] u;
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t              vec;
    logic [NORM_W-1:0] norm;
  } entry_t;

  // commands from the sequencer to the cell row
  typedef struct packed {
    logic insert;
    logic drain;
  } cell_cmd_t;

endpackage

>>> hdl/vector_norm_sorter.sv
// ----------------------------------------------------------------------------
// vector_norm_sorter
// Collects four-component Q8.8 vectors with their Euclidean norms and sends
// them back in ascending norm order when a set ends.
// ----------------------------------------------------------------------------
// Usage:
//   vec_* channel takes one vector word at a time. vec_ready is low while the
//   norm of the previous vector is worked out: after a word is accepted, the
//   next is taken only after a load, 5 squaring steps on the shared
//   multiplier, 17 root digits and an insert into the sorted cells.
//   A word with last_vector set starts a sorted run on the res_* channel
//   once its own norm is inserted or dropped: one result word per cycle
//   while res_ready is high, out_last on the final one, overflow on all
//   words of a set that lost vectors.
//   Vectors arriving while MAX_VECTORS are already held are dropped.
//   While the receiver stalls the head word holds and no vector is taken;
//   the next set starts after the final result is accepted.
//   Reset empties the store and clears the overflow mark; no clearing pass.
// ----------------------------------------------------------------------------
module vector_norm_sorter #(
  parameter int MAX_VECTORS = vns_pkg::MAX_VECTORS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                vec_valid,
  output logic                vec_ready,
  input  vns_pkg::vec_word_t  vec_word,
  output logic                res_valid,
  input  logic                res_ready,
  output vns_pkg::res_word_t  res_word
);
  import vns_pkg::*;

  localparam int CNT_W = $clog2(MAX_VECTORS + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CALC  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic              dropped;
  logic              last_pend;
  vec_t              vec;
  logic              vec_acc;
  logic              res_acc;
  logic              norm_done;
  logic [NORM_W-1:0] norm;
  cell_cmd_t         cmd;
  entry_t            new_entry;
  entry_t            head;
  logic              full;

  assign vec_ready = state == S_IDLE;
  assign vec_acc   = vec_valid && vec_ready;
  assign res_valid = state == S_DRAIN;
  assign res_acc   = res_valid && res_ready;
  assign full      = count == CNT_W'(MAX_VECTORS);

  vns_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (vec_acc),
    .vec   ({vec_word.comp_u, vec_word.comp_x, vec_word.comp_y, vec_word.comp_z}),
    .done  (norm_done),
    .norm  (norm)
  );

  assign new_entry.vec  = vec;
  assign new_entry.norm = norm;
  assign cmd.insert     = state == S_CALC && norm_done && !full;
  assign cmd.drain      = res_acc;

  vns_cells #(
    .MAX_VECTORS (MAX_VECTORS),
    .CNT_W       (CNT_W)
  ) u_cells (
    .clk       (clk),
    .cmd       (cmd),
    .new_entry (new_entry),
    .count     (count),
    .head      (head)
  );

  // hold the accepted vector for insertion
  always_ff @(posedge clk) begin
    if (vec_acc) begin
      vec       <= {vec_word.comp_u, vec_word.comp_x, vec_word.comp_y, vec_word.comp_z};
      last_pend <= vec_word.last_vector;
    end
  end

  // sequence load, insert and drain
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (vec_acc) state <= S_CALC;
        end
        S_CALC: begin
          if (norm_done) begin
            if (full) dropped <= 1'b1;
            else      count   <= count + 1'b1;
            state <= last_pend ? S_DRAIN : S_IDLE;
          end
        end
        S_DRAIN: begin
          if (res_acc) begin
            count <= count - 1'b1;
            if (count == CNT_W'(1)) begin
              state   <= S_IDLE;
              dropped <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res_word.out_u    = head.vec.u;
  assign res_word.out_x    = head.vec.x;
  assign res_word.out_y    = head.vec.y;
  assign res_word.out_z    = head.vec.z;
  assign res_word.out_norm = head.norm;
  assign res_word.out_last = count == CNT_W'(1);
  assign res_word.overflow = dropped;

  // a run never shows an empty store
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> count != '0)
    else $error("result shown with empty store");

  // store never grows past capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_VECTORS))
    else $error("stored count beyond capacity");

  // an accepted vector starts a norm computation
  a_accept_calc: assert property (@(posedge clk) disable iff (rst)
    vec_acc |=> state == S_CALC)
    else $error("accepted vector not processed");

  // final result of a run returns the block to idle with an empty store
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (res_acc && res_word.out_last) |=> (vec_ready && count == '0 && !dropped))
    else $error("run did not end cleanly");

endmodule

>>> hdl/vns_norm.sv
// ----------------------------------------------------------------------------
// vns_norm
// Iterative Euclidean norm: one shared multiplier squares the four magnitudes
// in turn, then a digit-by-digit square root gives one root bit per cycle.
// ----------------------------------------------------------------------------
module vns_norm (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  vns_pkg::vec_t        vec,
  output logic                 done,
  output logic [vns_pkg::NORM_W-1:0] norm
);
  import vns_pkg::*;

  typedef enum logic [3:0] {
    N_IDLE = 4'b0001,
    N_SQ   = 4'b0010,
    N_ROOT = 4'b0100,
    N_DONE = 4'b1000
  } nstate_t;

  nstate_t                 state;
  logic [STEP_W-1:0]       step;
  logic [COMP_W-1:0]       mag [4];
  logic [2*COMP_W-1:0]     prod;
  logic [SUM_W-1:0]        acc;
  logic [SUM_W-1:0]        acc_next;
  logic [RAD_W-1:0]        rad;
  logic [REM_W-1:0]        rem;
  logic [ROOT_W-1:0]       root;
  logic [REM_W+1:0]        rem_sh;
  logic [REM_W+1:0]        trial;
  logic                    take;

  function automatic logic [COMP_W-1:0] abs16(input logic signed [COMP_W-1:0] c);
    abs16 = c[COMP_W-1] ? COMP_W'(-c) : COMP_W'(c);
  endfunction

  assign acc_next = acc + SUM_W'(prod);

  // one root digit: bring down two radicand bits, try to subtract 4r+1
  assign rem_sh = {rem, rad[RAD_W-1 -: 2]};
  assign trial  = (REM_W+2)'({root, 2'b01});
  assign take   = rem_sh >= trial;

  // sequence squaring then root extraction
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        N_IDLE: begin
          if (start) begin
            state <= N_SQ;
            step  <= '0;
          end
        end
        N_SQ: begin
          if (step == STEP_W'(SQ_STEPS - 1)) begin
            state <= N_ROOT;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        N_ROOT: begin
          if (step == STEP_W'(ROOT_STEPS - 1)) begin
            state <= N_DONE;
          end else begin
            step <= step + 1'b1;
          end
        end
        N_DONE: begin
          state <= N_IDLE;
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  // datapath: load, square and accumulate, extract root
  always_ff @(posedge clk) begin
    if (state == N_IDLE && start) begin
      mag[0] <= abs16(vec.u);
      mag[1] <= abs16(vec.x);
      mag[2] <= abs16(vec.y);
      mag[3] <= abs16(vec.z);
      prod   <= '0;
      acc    <= '0;
    end else if (state == N_SQ) begin
      prod   <= mag[0] * mag[0];
      mag[0] <= mag[1];
      mag[1] <= mag[2];
      mag[2] <= mag[3];
      mag[3] <= '0;
      acc    <= acc_next;
      rad    <= RAD_W'(acc_next);
      rem    <= '0;
      root   <= '0;
    end else if (state == N_ROOT) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root <= {root[ROOT_W-2:0], take};
    end
  end

  assign done = state == N_DONE;
  // saturate the root at full scale
  assign norm = root[ROOT_W-1] ? {NORM_W{1'b1}} : root[NORM_W-1:0];

endmodule

>>> hdl/vns_cells.sv
// ----------------------------------------------------------------------------
// vns_cells
// Row of sorted cells. Each cell compares its norm with the incoming one, so
// insertion is done in parallel; draining shifts the row toward the head cell.
// ----------------------------------------------------------------------------
module vns_cells #(
  parameter int MAX_VECTORS = vns_pkg::MAX_VECTORS_DEF,
  parameter int CNT_W       = $clog2(MAX_VECTORS + 1)
) (
  input  logic               clk,
  input  vns_pkg::cell_cmd_t cmd,
  input  vns_pkg::entry_t    new_entry,
  input  logic [CNT_W-1:0]   count,
  output vns_pkg::entry_t    head
);
  import vns_pkg::*;

  entry_t cells [MAX_VECTORS];
  logic [MAX_VECTORS-1:0] gt;

  genvar i;
  generate
    for (i = 0; i < MAX_VECTORS; i++) begin : g_cell
      // occupied cell holding a larger norm moves up one place
      assign gt[i] = (count > CNT_W'(i)) && (cells[i].norm > new_entry.norm);

      always_ff @(posedge clk) begin
        if (cmd.insert) begin
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            cells[i] <= cells[(i > 0) ? i - 1 : 0];
          end else if (gt[i] || count == CNT_W'(i)) begin
            cells[i] <= new_entry;
          end
        end else if (cmd.drain) begin
          if (i < MAX_VECTORS - 1) begin
            cells[i] <= cells[(i < MAX_VECTORS - 1) ? i + 1 : i];
          end
        end
      end
    end
  endgenerate

  assign head = cells[0];

endmodule
